// File: hw/rtl/sas_pkg.sv
package sas_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam logic [6:0]  CAPACITY_RESET = 7'd64;
  localparam logic [31:0] DATA_FAIL      = 32'hFFFF_FFFF;

  // opcodes carried in s_tuser
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_SORT   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_INS_RD,
    ST_INS_WR,
    ST_GET_WAIT,
    ST_REM_FIRST,
    ST_REM_RD,
    ST_REM_WR,
    ST_SRT_KEY,
    ST_SRT_LOAD,
    ST_SRT_RD,
    ST_SRT_CMP,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/sortable_array_store.sv
// channel   | dir | handshake            | payload
// ----------+-----+----------------------+---------------------------------------------
// s_*       | in  | s_tvalid / s_tready  | tuser: opcode; tdata: position, value
// m_*       | out | m_tvalid / m_tready  | tuser: ok; tdata: data, entries_held
// cfg_*     | in  | cfg_valid / cfg_ready| cfg_data: capacity
//
// one request at a time; s_tready is high only while the sequencer is idle
// the single read port of the entry memory, one read per element moved, sets the pace
// rst clears the held count, capacity (to 64) and control; entry contents are not cleared
// a result waiting on m_tready holds the sequencer in its final state; cfg_ready is always high
module sortable_array_store #(
  parameter int DEPTH = sas_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] data, [38:32] entries_held, [39] zero
  output logic        m_tuser,   // [0] ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // [6:0] capacity
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > 7) ? CW : 7;

  sas_pkg::state_t state, state_next;

  logic [31:0]   mem [DEPTH];
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;
  logic [AW-1:0] ra;
  logic [31:0]   rd_q;

  logic [6:0]    capacity;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [2:0]    op;
  logic [6:0]    pos;
  logic [31:0]   val, val_next;
  logic          ok, ok_next;
  logic [31:0]   data, data_next;

  logic          out_ok;
  logic [31:0]   out_data;
  logic [6:0]    out_held;

  logic [WW-1:0] fill_w, pos_w, cap_w, j_w;
  logic [CW-1:0] jm1, jp1;
  logic          room;
  logic          out_free;

  assign fill_w   = WW'(fill);
  assign pos_w    = WW'(pos);
  assign cap_w    = WW'(capacity);
  assign j_w      = WW'(j);
  assign jm1      = j - CW'(1);
  assign jp1      = j + CW'(1);
  assign room     = (fill_w < cap_w) && (fill_w < WW'(DEPTH));
  assign out_free = !m_tvalid || m_tready;

  assign s_tready  = (state == sas_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, out_held, out_data};
  assign m_tuser   = out_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_comb begin
    state_next = state;
    fill_next  = fill;
    i_next     = i;
    j_next     = j;
    val_next   = val;
    ok_next    = ok;
    data_next  = data;
    we         = 1'b0;
    wa         = j[AW-1:0];
    wd         = val;
    ra         = j[AW-1:0];
    unique case (state)
      sas_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = sas_pkg::ST_START;
        end
        val_next = s_tdata[38:7];
      end
      sas_pkg::ST_START: begin
        ok_next   = 1'b0;
        data_next = '0;
        state_next = sas_pkg::ST_DONE;
        case (op)
          sas_pkg::OP_APPEND: begin
            if (room) begin
              we        = 1'b1;
              wa        = fill[AW-1:0];
              fill_next = fill + CW'(1);
              ok_next   = 1'b1;
            end
          end
          sas_pkg::OP_INSERT: begin
            if (pos_w <= fill_w && room) begin
              j_next     = fill;
              state_next = sas_pkg::ST_INS_RD;
            end
          end
          sas_pkg::OP_GET: begin
            if (pos_w < fill_w) begin
              ra         = pos_w[AW-1:0];
              state_next = sas_pkg::ST_GET_WAIT;
            end else begin
              data_next = sas_pkg::DATA_FAIL;
            end
          end
          sas_pkg::OP_REMOVE: begin
            if (pos_w < fill_w) begin
              ra         = pos_w[AW-1:0];
              j_next     = pos_w[CW-1:0];
              state_next = sas_pkg::ST_REM_FIRST;
            end else begin
              data_next = sas_pkg::DATA_FAIL;
            end
          end
          sas_pkg::OP_SORT: begin
            ok_next    = 1'b1;
            i_next     = CW'(1);
            state_next = sas_pkg::ST_SRT_KEY;
          end
          default: begin
          end
        endcase
      end
      // shift the tail up one place, from the top down to the insert point
      sas_pkg::ST_INS_RD: begin
        if (j_w > pos_w) begin
          ra         = jm1[AW-1:0];
          state_next = sas_pkg::ST_INS_WR;
        end else begin
          we         = 1'b1;
          fill_next  = fill + CW'(1);
          ok_next    = 1'b1;
          state_next = sas_pkg::ST_DONE;
        end
      end
      sas_pkg::ST_INS_WR: begin
        we         = 1'b1;
        wd         = rd_q;
        j_next     = jm1;
        state_next = sas_pkg::ST_INS_RD;
      end
      sas_pkg::ST_GET_WAIT: begin
        data_next  = rd_q;
        ok_next    = 1'b1;
        state_next = sas_pkg::ST_DONE;
      end
      sas_pkg::ST_REM_FIRST: begin
        data_next  = rd_q;
        ok_next    = 1'b1;
        state_next = sas_pkg::ST_REM_RD;
      end
      // close the gap, moving each later entry down one place
      sas_pkg::ST_REM_RD: begin
        if (jp1 < fill) begin
          ra         = jp1[AW-1:0];
          state_next = sas_pkg::ST_REM_WR;
        end else begin
          fill_next  = fill - CW'(1);
          state_next = sas_pkg::ST_DONE;
        end
      end
      sas_pkg::ST_REM_WR: begin
        we         = 1'b1;
        wd         = rd_q;
        j_next     = jp1;
        state_next = sas_pkg::ST_REM_RD;
      end
      sas_pkg::ST_SRT_KEY: begin
        ra = i[AW-1:0];
        j_next = i;
        if (i < fill) begin
          state_next = sas_pkg::ST_SRT_LOAD;
        end else begin
          state_next = sas_pkg::ST_DONE;
        end
      end
      sas_pkg::ST_SRT_LOAD: begin
        val_next   = rd_q;
        state_next = sas_pkg::ST_SRT_RD;
      end
      sas_pkg::ST_SRT_RD: begin
        if (j != '0) begin
          ra         = jm1[AW-1:0];
          state_next = sas_pkg::ST_SRT_CMP;
        end else begin
          we         = 1'b1;
          i_next     = i + CW'(1);
          state_next = sas_pkg::ST_SRT_KEY;
        end
      end
      // strict signed compare keeps equal keys in their order
      sas_pkg::ST_SRT_CMP: begin
        we = 1'b1;
        if ($signed(rd_q) > $signed(val)) begin
          wd         = rd_q;
          j_next     = jm1;
          state_next = sas_pkg::ST_SRT_RD;
        end else begin
          i_next     = i + CW'(1);
          state_next = sas_pkg::ST_SRT_KEY;
        end
      end
      sas_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = sas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sas_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sas_pkg::ST_IDLE;
      fill     <= '0;
      capacity <= sas_pkg::CAPACITY_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (state == sas_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i    <= i_next;
    j    <= j_next;
    val  <= val_next;
    ok   <= ok_next;
    data <= data_next;
    if (s_tvalid && s_tready) begin
      op  <= s_tuser;
      pos <= s_tdata[6:0];
    end
    if (state == sas_pkg::ST_DONE && out_free) begin
      out_ok   <= ok;
      out_data <= data;
      out_held <= fill_w[6:0];
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_w <= WW'(DEPTH))
    else $error("held count above depth");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  a_held_reported: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> m_tdata[38:32] == fill_w[6:0])
    else $error("reported count differs from held count");

  a_sort_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == sas_pkg::ST_SRT_RD || state == sas_pkg::ST_SRT_CMP) |-> j <= i && i < fill)
    else $error("sort cursor out of order");

  a_insert_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == sas_pkg::ST_INS_WR) |-> j_w > pos_w && j <= fill)
    else $error("insert shift out of range");
`endif

endmodule

// File: tb/sas_checker.sv
module sas_checker #(
  parameter int DEPTH = sas_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [31:0] data, [38:32] entries_held, [39] zero
  input  logic        m_tuser,   // [0] ok
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,  // [6:0] capacity
  output int          error_count,
  output int          results_due,
  output int          held_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic [31:0] data;
    logic [6:0]  held;
  } store_result_t;

  logic signed [31:0] words [DEPTH];
  int                 fill;
  logic [6:0]         capacity;
  store_result_t      result_q [$];

  // applies one request to the shadow store and returns what the block should answer
  function automatic store_result_t apply_request(logic [2:0] op, logic [6:0] pos,
                                                  logic [31:0] val);
    store_result_t      r;
    int                 lim;
    int                 i;
    int                 j;
    logic signed [31:0] key;
    lim    = (capacity < DEPTH) ? int'(capacity) : DEPTH;
    r.ok   = 1'b0;
    r.data = '0;
    case (op)
      sas_pkg::OP_APPEND: begin
        if (fill < lim) begin
          words[fill] = val;
          fill++;
          r.ok = 1'b1;
        end
      end
      sas_pkg::OP_INSERT: begin
        if (int'(pos) <= fill && fill < lim) begin
          for (i = fill; i > int'(pos); i--)
            words[i] = words[i-1];
          words[pos] = val;
          fill++;
          r.ok = 1'b1;
        end
      end
      sas_pkg::OP_GET: begin
        if (int'(pos) < fill) begin
          r.data = words[pos];
          r.ok   = 1'b1;
        end else begin
          r.data = sas_pkg::DATA_FAIL;
        end
      end
      sas_pkg::OP_REMOVE: begin
        if (int'(pos) < fill) begin
          r.data = words[pos];
          for (i = int'(pos); i + 1 < fill; i++)
            words[i] = words[i+1];
          fill--;
          r.ok = 1'b1;
        end else begin
          r.data = sas_pkg::DATA_FAIL;
        end
      end
      sas_pkg::OP_SORT: begin
        // stable: only strictly greater words move past the key
        for (i = 1; i < fill; i++) begin
          key = words[i];
          j   = i;
          while (j > 0 && words[j-1] > key) begin
            words[j] = words[j-1];
            j--;
          end
          words[j] = key;
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.held = fill[6:0];
    return r;
  endfunction

  task automatic flag_error(string what, store_result_t want, store_result_t seen);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] %s: expected ok=%0b data=%0d held=%0d, got ok=%0b data=%0d held=%0d",
               $realtime, what, want.ok, $signed(want.data), want.held,
               seen.ok, $signed(seen.data), seen.held);
  endtask

  always @(posedge clk) begin : monitor
    store_result_t seen;
    store_result_t want;
    if (rst) begin
      fill        = 0;
      capacity    = sas_pkg::CAPACITY_RESET;
      error_count = 0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        capacity = cfg_data;
      if (s_tvalid && s_tready)
        result_q.push_back(apply_request(s_tuser, s_tdata[6:0], s_tdata[38:7]));
      if (m_tvalid && m_tready) begin
        seen = {m_tuser, m_tdata[31:0], m_tdata[38:32]};
        if (result_q.size() == 0) begin
          flag_error("result with no request pending", '0, seen);
        end else begin
          want = result_q.pop_front();
          if (seen !== want)
            flag_error("result mismatch", want, seen);
        end
      end
    end
    results_due = result_q.size();
    held_count  = fill;
  end

endmodule

// File: tb/tb_sortable_array_store.sv
module tb_sortable_array_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIMIT_CYCLES    = 10_000_000;
  localparam int          SETTLE_CYCLES   = 64;
  localparam int          RANDOM_ITEMS    = 400;
  localparam int          NUM_SEGMENTS    = 9;
  localparam logic [2:0]  OP_UNUSED_FIRST = sas_pkg::OP_SORT + 3'd1;
  localparam logic [31:0] WORD_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN        = 32'h8000_0000;
  localparam logic [31:0] WORD_NEG_ONE    = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  int error_count;
  int results_due;
  int held_count;
  int send_idle_pct = 18;
  int recv_idle_pct = 78;
  int cycle_count;

  sortable_array_store u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sas_checker #(.DEPTH(sas_pkg::DEPTH_DEFAULT)) u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .results_due (results_due),
    .held_count  (held_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // valid stays up between back-to-back requests; the next call drops it only for idle gaps
  task automatic send_request(logic [2:0] op, logic [6:0] pos, logic [31:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {1'b0, val, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [6:0] cap);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data  = cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_request(int add_pct, int remove_pct);
    logic [2:0]  op;
    logic [6:0]  pos;
    logic [31:0] val;
    int          pick;
    pick = $urandom_range(99);
    if (pick < add_pct)
      op = ($urandom_range(1) == 0) ? sas_pkg::OP_APPEND : sas_pkg::OP_INSERT;
    else if (pick < add_pct + remove_pct)
      op = sas_pkg::OP_REMOVE;
    else begin
      pick = $urandom_range(9);
      if (pick < 6)
        op = sas_pkg::OP_GET;
      else if (pick < 8)
        op = sas_pkg::OP_SORT;
      else
        op = OP_UNUSED_FIRST + 3'($urandom_range(2));
    end
    // mostly in-range positions, some anywhere in the field
    pos = 7'($urandom_range(127));
    if ($urandom_range(99) < 85) begin
      if (op == sas_pkg::OP_INSERT)
        pos = 7'($urandom_range(held_count));
      else if ((op == sas_pkg::OP_GET || op == sas_pkg::OP_REMOVE) && held_count > 0)
        pos = 7'($urandom_range(held_count - 1));
    end
    pick = $urandom_range(9);
    if (pick < 5)
      val = $urandom;
    else if (pick < 8)
      val = $urandom_range(16) - 32'd8;
    else if (pick == 8)
      val = WORD_MAX;
    else
      val = WORD_MIN;
    send_request(op, pos, val);
  endtask

  initial begin : stimulus
    int seg;
    int sent;
    int seg_cap;
    int seg_add;
    int seg_remove;
    int seg_items;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = sas_pkg::OP_APPEND;
    cfg_valid = 1'b0;
    cfg_data  = sas_pkg::CAPACITY_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty store
    send_request(sas_pkg::OP_GET, 7'd0, $urandom);
    send_request(sas_pkg::OP_REMOVE, 7'd0, $urandom);
    send_request(sas_pkg::OP_SORT, 7'd0, $urandom);
    send_request(sas_pkg::OP_APPEND, 7'd0, WORD_MAX);
    send_request(sas_pkg::OP_APPEND, 7'd127, WORD_MIN);
    send_request(sas_pkg::OP_APPEND, 7'd0, 32'd0);
    send_request(sas_pkg::OP_APPEND, 7'd0, WORD_NEG_ONE);
    send_request(sas_pkg::OP_INSERT, 7'd0, 32'd5);
    send_request(sas_pkg::OP_INSERT, 7'd5, -32'sd5);
    send_request(sas_pkg::OP_INSERT, 7'd127, 32'd9);
    send_request(sas_pkg::OP_GET, 7'd0, $urandom);
    send_request(sas_pkg::OP_GET, 7'd5, $urandom);
    send_request(sas_pkg::OP_GET, 7'd127, $urandom);
    send_request(sas_pkg::OP_SORT, 7'd0, $urandom);
    send_request(sas_pkg::OP_GET, 7'd0, $urandom);
    send_request(sas_pkg::OP_REMOVE, 7'd2, $urandom);
    send_request(sas_pkg::OP_REMOVE, 7'd5, $urandom);
    send_request(sas_pkg::OP_REMOVE, 7'd0, $urandom);
    send_request(OP_UNUSED_FIRST, 7'd0, $urandom);
    send_request(OP_UNUSED_FIRST + 3'd1, 7'd127, $urandom);
    send_request(OP_UNUSED_FIRST + 3'd2, 7'd0, $urandom);
    // zero capacity, then capacity below the held count
    write_capacity(7'd0);
    send_request(sas_pkg::OP_APPEND, 7'd0, 32'd1);
    send_request(sas_pkg::OP_INSERT, 7'd0, 32'd2);
    write_capacity(7'd2);
    send_request(sas_pkg::OP_APPEND, 7'd0, 32'd3);
    send_request(sas_pkg::OP_REMOVE, 7'd0, $urandom);
    send_request(sas_pkg::OP_SORT, 7'd0, $urandom);

    sent = 0;
    for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
      case (seg)
        0:       begin seg_cap = 127; seg_add = 85; seg_remove = 5;  seg_items = 80; end
        1:       begin seg_cap = 5;   seg_add = 5;  seg_remove = 80; seg_items = 60; end
        2:       begin seg_cap = 64;  seg_add = 50; seg_remove = 25; seg_items = 40; end
        3:       begin seg_cap = 0;   seg_add = 40; seg_remove = 20; seg_items = 30; end
        4:       begin seg_cap = 1;   seg_add = 5;  seg_remove = 85; seg_items = 40; end
        5:       begin seg_cap = 16;  seg_add = 60; seg_remove = 20; seg_items = 40; end
        6:       begin seg_cap = 3;   seg_add = 40; seg_remove = 30; seg_items = 30; end
        7:       begin seg_cap = 100; seg_add = 50; seg_remove = 25; seg_items = 40; end
        default: begin seg_cap = 64;  seg_add = 45; seg_remove = 30; seg_items = 40; end
      endcase
      write_capacity(7'(seg_cap));
      repeat (seg_items) begin
        if (sent == RANDOM_ITEMS / 3) begin
          send_idle_pct = 78;
          recv_idle_pct = 18;
        end else if (sent == 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_random_request(seg_add, seg_remove);
        sent++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sas_pkg.sv
hw/rtl/sortable_array_store.sv
tb/sas_checker.sv
tb/tb_sortable_array_store.sv
